[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// Clocked property checks used by the list engine controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define ASSERT_RESET(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg: positional list engine package
// Sizes, command and status codes, word types and the cell control struct.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 6;
  localparam int CMP_W    = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

  localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd3;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;
  localparam logic [1:0] CELL_ROT  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [TOTAL_W-1:0]        entry_total;
    logic signed [VALUE_W-1:0] entry_value;
    logic                      last;
  } rsp_t;

  // broadcast to every cell; idx is the insert/delete point or the tail on rotate
  typedef struct packed {
    logic [1:0]         cmd;
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

[hw/rtl/ple_cell.sv]
// ----------------------------------------------------------------------------
// ple_cell: one list entry
// Holds one word and loads it from the broadcast value, a neighbor or the head word.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [IDX_W-1:0]   index,
  input  logic [VALUE_W-1:0] left_value,
  input  logic [VALUE_W-1:0] right_value,
  input  logic [VALUE_W-1:0] head_value,
  output logic [VALUE_W-1:0] value
);

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CELL_INS: begin
        if (index == ctrl.idx) begin
          value <= ctrl.value;
        end else if (index > ctrl.idx) begin
          value <= left_value;
        end
      end
      CELL_DEL: begin
        if (index >= ctrl.idx) begin
          value <= right_value;
        end
      end
      CELL_ROT: begin
        // tail wraps the head word around so the list comes back after a dump
        if (index == ctrl.idx) begin
          value <= head_value;
        end else if (index < ctrl.idx) begin
          value <= right_value;
        end
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

[hw/rtl/ple_ctrl.sv]
// ----------------------------------------------------------------------------
// ple_ctrl: list engine controller
// Decodes commands, keeps the entry count, drives the cells, forms results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ple_ctrl import ple_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cmd_t               cmd,
  input  logic [VALUE_W-1:0] head_value,
  output logic               busy,
  output logic               strobe,
  output rsp_t               rsp,
  output cell_ctrl_t         cell_ctrl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic               state;
  logic               state_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] dump_left;
  logic [COUNT_W-1:0] dump_left_next;
  logic               strobe_next;
  rsp_t               rsp_next;

  logic               accept;
  logic               full;
  logic               empty;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic [IDX_W-1:0]   pos_idx;
  logic [IDX_W-1:0]   tail_idx;
  logic [STATUS_W-1:0] status;

  assign busy     = (state == S_DUMP);
  assign accept   = start && !busy;
  assign full     = (count == COUNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign pos_ext  = CMP_W'(cmd.position);
  assign cnt_ext  = CMP_W'(count);
  assign pos_idx  = IDX_W'(pos_ext - CMP_W'(1));
  assign tail_idx = IDX_W'(count - COUNT_W'(1));

  always_comb begin
    state_next     = state;
    count_next     = count;
    dump_left_next = dump_left;
    strobe_next    = 1'b0;
    status         = ST_OK;
    cell_ctrl.cmd   = CELL_HOLD;
    cell_ctrl.idx   = '0;
    cell_ctrl.value = cmd.value;
    rsp_next.status      = ST_OK;
    rsp_next.entry_total = '0;
    rsp_next.entry_value = '0;
    rsp_next.last        = 1'b1;

    if (state == S_DUMP) begin
      cell_ctrl.cmd        = CELL_ROT;
      cell_ctrl.idx        = tail_idx;
      strobe_next          = 1'b1;
      rsp_next.entry_total = TOTAL_W'(count);
      rsp_next.entry_value = head_value;
      rsp_next.last        = (dump_left == COUNT_W'(1));
      dump_left_next       = dump_left - COUNT_W'(1);
      if (dump_left == COUNT_W'(1)) begin
        state_next = S_IDLE;
      end
    end else if (accept) begin
      strobe_next = 1'b1;
      case (cmd.op)
        OP_INS_FIRST: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            cell_ctrl.cmd = CELL_INS;
            cell_ctrl.idx = '0;
            count_next    = count + COUNT_W'(1);
          end
        end
        OP_INS_LAST: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            cell_ctrl.cmd = CELL_INS;
            cell_ctrl.idx = IDX_W'(count);
            count_next    = count + COUNT_W'(1);
          end
        end
        OP_DEL_FIRST: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            cell_ctrl.cmd = CELL_DEL;
            cell_ctrl.idx = '0;
            count_next    = count - COUNT_W'(1);
          end
        end
        OP_DEL_LAST: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            cell_ctrl.cmd = CELL_DEL;
            cell_ctrl.idx = tail_idx;
            count_next    = count - COUNT_W'(1);
          end
        end
        OP_INS_AT: begin
          if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
            status = ST_BADPOS;
          end else if (full) begin
            status = ST_FULL;
          end else begin
            cell_ctrl.cmd = CELL_INS;
            cell_ctrl.idx = pos_idx;
            count_next    = count + COUNT_W'(1);
          end
        end
        OP_DEL_AT: begin
          if (empty) begin
            status = ST_EMPTY;
          end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
            status = ST_BADPOS;
          end else begin
            cell_ctrl.cmd = CELL_DEL;
            cell_ctrl.idx = pos_idx;
            count_next    = count - COUNT_W'(1);
          end
        end
        OP_DUMP: begin
          // a non-empty dump streams from the DUMP state, one word a cycle
          if (!empty) begin
            strobe_next    = 1'b0;
            state_next     = S_DUMP;
            dump_left_next = count;
          end
        end
        default: begin
          status = ST_OK;
        end
      endcase
      rsp_next.status      = status;
      rsp_next.entry_total = TOTAL_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dump_left <= '0;
      strobe    <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dump_left <= dump_left_next;
      strobe    <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (strobe_next) begin
      rsp <= rsp_next;
    end
  end

  `ASSERT_ALWAYS(a_count_cap, clk, rst, count <= COUNT_W'(CAPACITY), "count above capacity")
  `ASSERT_ALWAYS(a_dump_left, clk, rst, state == S_DUMP |-> dump_left != '0, "dump with nothing left")
  `ASSERT_ALWAYS(a_single_word, clk, rst, (accept && cmd.op != OP_DUMP) |=> (strobe && rsp.last), "missing result word")
  `ASSERT_ALWAYS(a_full_status, clk, rst, (strobe && rsp.status == ST_FULL) |-> full, "full status on non-full list")
  `ASSERT_RESET(a_reset_quiet, clk, rst |=> !strobe && !busy, "activity right after reset")

endmodule

[hw/rtl/positional_list_engine.sv]
// latency: a non-dump command gives its one result word in the cycle after it is accepted
// throughput: non-dump commands are accepted every cycle while busy is low, each cell shifts in one step
// a dump of n entries holds busy in the DUMP state and gives n words, the last with rsp.last set
// the cell chain rotates one word to the head per cycle, which sets the dump length
// the receiver cannot stall: every strobed word is taken in its cycle
// reset clears the entry count and the strobe; the entry cells are not cleared
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list with positional insert and delete
// Controller plus a chain of entry cells that shift toward or away from the head.
// ----------------------------------------------------------------------------
module positional_list_engine import ple_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic strobe,
  output rsp_t rsp
);

  cell_ctrl_t         cell_ctrl;
  logic [VALUE_W-1:0] cell_value [CAPACITY];
  logic [VALUE_W-1:0] cell_left  [CAPACITY];
  logic [VALUE_W-1:0] cell_right [CAPACITY];

  ple_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .head_value (cell_value[0]),
    .busy       (busy),
    .strobe     (strobe),
    .rsp        (rsp),
    .cell_ctrl  (cell_ctrl)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign cell_left[g] = '0;
    end else begin : g_mid_left
      assign cell_left[g] = cell_value[g-1];
    end
    if (g == CAPACITY - 1) begin : g_final
      assign cell_right[g] = '0;
    end else begin : g_mid_right
      assign cell_right[g] = cell_value[g+1];
    end

    ple_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl),
      .index       (IDX_W'(g)),
      .left_value  (cell_left[g]),
      .right_value (cell_right[g]),
      .head_value  (cell_value[0]),
      .value       (cell_value[g])
    );
  end

endmodule
